>>> src/stt_pkg.sv
package stt_pkg;

  // Default sizes of the timer table
  localparam int unsigned SLOTS_DEF     = 32;
  localparam int unsigned MAX_FIRED_DEF = 16;

  // Operation codes of a request
  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // One request
  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  timer_slot;
    logic [31:0] timeout;
  } stt_req_t;

  // One result
  typedef struct packed {
    logic        fired_valid;
    logic [4:0]  fired_slot;
    logic [63:0] now_ticks;
    logic        last;
  } stt_rsp_t;

endpackage

>>> src/stt_ram.sv
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/software_timer_table_unit.sv
// Timer table: SLOTS one-shot timers kept as a singly linked list, with a
// 64-bit tick counter. Expiry times and links sit in two RAMs with one write
// port, one read port and a registered read; active flags and the list head
// are flip-flops. For an arm, a cancel of an idle or out-of-range slot and
// the unused code, the single result appears on the cycle after the request.
// Cancel of an active slot walks the list up to the slot. Tick walks the list
// one entry per cycle, since each entry's link read feeds the next read
// address. A fired slot is reported in the cycle after the walk finds the
// next fired slot; the final one is built in the flush state after the
// walk's last step and then registered, with last set. busy stays high for
// the whole walk; results cannot be held off and each is valid for exactly
// one cycle on rsp_valid_o.
module software_timer_table_unit #(
  parameter int unsigned SLOTS     = stt_pkg::SLOTS_DEF,
  parameter int unsigned MAX_FIRED = stt_pkg::MAX_FIRED_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  stt_pkg::stt_req_t req_i,
  output logic             rsp_valid_o,
  output stt_pkg::stt_rsp_t rsp_o
);

  import stt_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned NW = $clog2(MAX_FIRED + 1);
  localparam logic [LW-1:0] LINK_END  = LW'(SLOTS);
  localparam logic [NW-1:0] FIRED_MAX = NW'(MAX_FIRED);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CWALK = 4'b0010,
    S_TWALK = 4'b0100,
    S_FLUSH = 4'b1000
  } stt_state_e;

  stt_state_e state_q, state_d;
  logic [63:0]    now_q, now_d;
  logic [LW-1:0]  head_q, head_d;
  logic [SLOTS-1:0] active_q, active_d;
  logic [LW-1:0]  steps_q, steps_d;
  logic [NW-1:0]  n_q, n_d;
  logic           pend_v_q, pend_v_d;
  logic [SW-1:0]  pend_slot_q, pend_slot_d;
  logic [LW-1:0]  cur_q, cur_d;
  logic [LW-1:0]  prev_q, prev_d;
  logic [SW-1:0]  slot_q, slot_d;
  logic           rsp_valid_q, rsp_valid_d;
  stt_rsp_t       rsp_q, rsp_d;

  // RAM ports
  logic [SW-1:0]  raddr;
  logic           link_we;
  logic [SW-1:0]  link_waddr;
  logic [LW-1:0]  link_wdata;
  logic [LW-1:0]  link_rdata;
  logic           exp_we;
  logic [63:0]    exp_wdata;
  logic [63:0]    exp_rdata;

  // Request decode
  logic           s_ok;
  logic [SW-1:0]  s_idx;
  logic [63:0]    delay_ext;
  logic           fired;
  logic [LW-1:0]  steps_nxt;
  logic [NW-1:0]  n_nxt;

  assign s_ok      = 32'(req_i.timer_slot) < 32'(SLOTS);
  assign s_idx     = SW'(req_i.timer_slot);
  assign delay_ext = 64'((req_i.timeout == '0) ? 32'd1 : req_i.timeout);
  assign fired     = exp_rdata <= now_q;
  assign steps_nxt = steps_q + LW'(1);
  assign n_nxt     = n_q + NW'(1);

  stt_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(raddr),
    .rdata_o(link_rdata)
  );

  stt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_expiry_ram (
    .clk_i  (clk_i),
    .we_i   (exp_we),
    .waddr_i(s_idx),
    .wdata_i(exp_wdata),
    .raddr_i(raddr),
    .rdata_o(exp_rdata)
  );

  // Sequence requests and list walks
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    head_d      = head_q;
    active_d    = active_q;
    steps_d     = steps_q;
    n_d         = n_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    slot_d      = slot_q;
    rsp_valid_d = 1'b0;
    rsp_d       = '{fired_valid: 1'b0, fired_slot: 5'd0, now_ticks: now_q, last: 1'b1};
    raddr       = cur_q[SW-1:0];
    link_we     = 1'b0;
    link_waddr  = prev_q[SW-1:0];
    link_wdata  = link_rdata;
    exp_we      = 1'b0;
    exp_wdata   = now_q + delay_ext;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_i.operation)
            OP_ARM: begin
              rsp_valid_d = 1'b1;
              if (s_ok) begin
                exp_we = 1'b1;
                // Link an idle slot at the head, keep an active one in place
                if (!active_q[s_idx]) begin
                  link_we          = 1'b1;
                  link_waddr       = s_idx;
                  link_wdata       = head_q;
                  head_d           = LW'(s_idx);
                  active_d[s_idx]  = 1'b1;
                end
              end
            end
            OP_CANCEL: begin
              if (s_ok && active_q[s_idx]) begin
                slot_d  = s_idx;
                prev_d  = LINK_END;
                cur_d   = head_q;
                steps_d = '0;
                if (head_q < LINK_END) begin
                  raddr   = head_q[SW-1:0];
                  state_d = S_CWALK;
                end else begin
                  active_d[s_idx] = 1'b0;
                  rsp_valid_d     = 1'b1;
                end
              end else begin
                rsp_valid_d = 1'b1;
              end
            end
            OP_TICK: begin
              now_d    = now_q + 64'd1;
              prev_d   = LINK_END;
              cur_d    = head_q;
              steps_d  = '0;
              n_d      = '0;
              pend_v_d = 1'b0;
              raddr    = head_q[SW-1:0];
              state_d  = (head_q < LINK_END) ? S_TWALK : S_FLUSH;
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_CWALK: begin
        if (cur_q[SW-1:0] == slot_q) begin
          // Unlink the target from its predecessor or the head
          if (prev_q >= LINK_END) begin
            head_d = link_rdata;
          end else begin
            link_we = 1'b1;
          end
          active_d[slot_q] = 1'b0;
          rsp_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rdata;
          steps_d = steps_nxt;
          if (link_rdata < LINK_END && steps_nxt < LINK_END) begin
            raddr = link_rdata[SW-1:0];
          end else begin
            active_d[slot_q] = 1'b0;
            rsp_valid_d      = 1'b1;
            state_d          = S_IDLE;
          end
        end
      end

      S_TWALK: begin
        if (fired) begin
          if (prev_q >= LINK_END) begin
            head_d = link_rdata;
          end else begin
            link_we = 1'b1;
          end
          active_d[cur_q[SW-1:0]] = 1'b0;
          // Release the previous fired slot, hold this one back
          if (pend_v_q) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{fired_valid: 1'b1, fired_slot: 5'(pend_slot_q),
                            now_ticks: now_q, last: 1'b0};
          end
          pend_v_d    = 1'b1;
          pend_slot_d = cur_q[SW-1:0];
          n_d         = n_nxt;
        end else begin
          prev_d = cur_q;
        end
        cur_d   = link_rdata;
        steps_d = steps_nxt;
        if (link_rdata < LINK_END && n_d < FIRED_MAX && steps_nxt < LINK_END) begin
          raddr = link_rdata[SW-1:0];
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        rsp_valid_d = 1'b1;
        rsp_d       = '{fired_valid: pend_v_q,
                        fired_slot: pend_v_q ? 5'(pend_slot_q) : 5'd0,
                        now_ticks: now_q, last: 1'b1};
        pend_v_d    = 1'b0;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      head_q      <= LINK_END;
      active_q    <= '0;
      steps_q     <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      head_q      <= head_d;
      active_q    <= active_d;
      steps_q     <= steps_d;
      n_q         <= n_d;
      pend_v_q    <= pend_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Walk pointers and result payload
  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    slot_q      <= slot_d;
    rsp_q       <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A final result always lands after the walk has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.last |-> state_q == S_IDLE)
    else $error("final result while a walk is running");

  // A non-final result only comes out of a tick walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.last |-> state_q == S_TWALK || state_q == S_FLUSH)
    else $error("non-final result outside a tick walk");

  // A walk only visits real slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TWALK || state_q == S_CWALK |-> cur_q < LINK_END)
    else $error("walk on the end marker");

  // A tick never removes more than the fired limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TWALK |-> n_q < FIRED_MAX)
    else $error("fired limit exceeded");

endmodule

>>> test/tb_software_timer_table_unit.sv
`timescale 1ns / 1ps

module tb_software_timer_table_unit;
  import stt_pkg::*;

  localparam int unsigned NSLOT      = SLOTS_DEF;
  localparam int unsigned NFIRE      = MAX_FIRED_DEF;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 60;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  stt_req_t req_i;
  logic     rsp_valid_o;
  stt_rsp_t rsp_o;

  software_timer_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // Shadow copy of the timer table
  logic [63:0] shadow_now;
  logic        shadow_active [NSLOT];
  logic [63:0] shadow_expiry [NSLOT];
  int unsigned shadow_link   [NSLOT];
  int unsigned shadow_head;

  stt_rsp_t    due_rsp_q [$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if it hangs
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
                 due_rsp_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Queue one expected result at the current tick count
  task automatic push_due(input logic fired, input int unsigned slot, input logic fin);
    stt_rsp_t r;
    r.fired_valid = fired;
    r.fired_slot  = fired ? slot[4:0] : 5'd0;
    r.now_ticks   = shadow_now;
    r.last        = fin;
    due_rsp_q.push_back(r);
  endtask

  // Apply one accepted request to the shadow table and queue its results
  task automatic apply_timer_request(input stt_req_t r);
    int unsigned prev;
    int unsigned cur;
    int unsigned nxt;
    int unsigned steps;
    int unsigned fired [$];
    int unsigned s;
    logic [63:0] delay;
    s = 32'(r.timer_slot);
    if (r.operation == OP_TICK) begin
      shadow_now++;
      prev  = NSLOT;
      cur   = shadow_head;
      steps = 0;
      // walk in list order; unlink expired slots up to the fire cap
      while (cur < NSLOT && fired.size() < NFIRE && steps < NSLOT) begin
        nxt = shadow_link[cur];
        if (shadow_expiry[cur] <= shadow_now) begin
          if (prev >= NSLOT) shadow_head = nxt;
          else shadow_link[prev] = nxt;
          shadow_active[cur] = 1'b0;
          shadow_link[cur]   = NSLOT;
          fired.push_back(cur);
        end else begin
          prev = cur;
        end
        cur = nxt;
        steps++;
      end
      if (fired.size() == 0) push_due(1'b0, 0, 1'b1);
      foreach (fired[k]) push_due(1'b1, fired[k], k == fired.size() - 1);
      return;
    end
    if (s < NSLOT) begin
      if (r.operation == OP_ARM) begin
        delay = (r.timeout == 32'd0) ? 64'd1 : {32'd0, r.timeout};
        shadow_expiry[s] = shadow_now + delay;
        // an idle slot goes to the head; an active one keeps its place
        if (!shadow_active[s]) begin
          shadow_active[s] = 1'b1;
          shadow_link[s]   = shadow_head;
          shadow_head      = s;
        end
      end else if (r.operation == OP_CANCEL && shadow_active[s]) begin
        prev  = NSLOT;
        cur   = shadow_head;
        steps = 0;
        while (cur < NSLOT && steps < NSLOT) begin
          nxt = shadow_link[cur];
          if (cur == s) begin
            if (prev >= NSLOT) shadow_head = nxt;
            else shadow_link[prev] = nxt;
            break;
          end
          prev = cur;
          cur  = nxt;
          steps++;
        end
        shadow_active[s] = 1'b0;
        shadow_link[s]   = NSLOT;
      end
    end
    push_due(1'b0, 0, 1'b1);
  endtask

  // Drive one request, hold it until accepted, then maybe pause
  task automatic send_request(input logic [1:0] op, input logic [4:0] slot,
                              input logic [31:0] delay);
    stt_req_t r;
    int unsigned gap;
    r.operation  = op;
    r.timer_slot = slot;
    r.timeout    = delay;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    apply_timer_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    stt_rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (due_rsp_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing due: %p", rsp_o));
      end else begin
        want = due_rsp_q.pop_front();
        if (rsp_o.fired_valid !== want.fired_valid)
          report_mismatch($sformatf("fired_valid got %b want %b",
                                    rsp_o.fired_valid, want.fired_valid));
        if (rsp_o.fired_slot !== want.fired_slot)
          report_mismatch($sformatf("fired_slot got %0d want %0d",
                                    rsp_o.fired_slot, want.fired_slot));
        if (rsp_o.now_ticks !== want.now_ticks)
          report_mismatch($sformatf("now_ticks got %0h want %0h",
                                    rsp_o.now_ticks, want.now_ticks));
        if (rsp_o.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", rsp_o.last, want.last));
      end
    end
  end

  // Rearm keeps list place, cancel in the middle, cancel of an idle slot,
  // zero and maximum delays, slot extremes
  task automatic test_rearm_and_cancel();
    send_request(OP_ARM, 5'd5, 32'd3);
    send_request(OP_ARM, 5'd6, 32'd1);
    send_request(OP_ARM, 5'd31, 32'd0);
    send_request(OP_ARM, 5'd5, 32'd1);
    send_request(OP_CANCEL, 5'd6, 32'd0);
    send_request(OP_CANCEL, 5'd9, 32'hFFFF_FFFF);
    send_request(OP_ARM, 5'd0, 32'hFFFF_FFFF);
    send_request(OP_TICK, 5'd0, 32'd0);
    send_request(OP_CANCEL, 5'd0, 32'd0);
  endtask

  // Unused operation code leaves the table alone
  task automatic test_unused_code();
    send_request(OP_UNUSED, 5'd31, 32'hFFFF_FFFF);
  endtask

  // More expired slots than one tick may report
  task automatic test_fire_cap();
    for (int unsigned i = 0; i < NFIRE + 1; i++)
      send_request(OP_ARM, i[4:0], 32'd1);
    send_request(OP_TICK, 5'd0, 32'd0);
    send_request(OP_TICK, 5'd0, 32'd0);
  endtask

  // Mostly short timers so ticks fire often; some long ones and noise
  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    logic [4:0]  slot;
    logic [31:0] delay;
    for (int unsigned n = 0; n < count; n++) begin
      pick  = $urandom_range(0, 99);
      slot  = 5'($urandom_range(0, NSLOT - 1));
      delay = $urandom;
      if (pick < 40) begin
        if ($urandom_range(0, 3) != 0) delay = $urandom_range(0, 12);
        send_request(OP_ARM, slot, delay);
      end else if (pick < 60) begin
        // favor slots that are actually armed
        if ($urandom_range(0, 1) == 1) begin
          for (int unsigned t = 0; t < NSLOT; t++) begin
            if (shadow_active[(32'(slot) + t) % NSLOT]) begin
              slot = 5'((32'(slot) + t) % NSLOT);
              break;
            end
          end
        end
        send_request(OP_CANCEL, slot, delay);
      end else if (pick < 96) begin
        send_request(OP_TICK, slot, delay);
      end else begin
        send_request(OP_UNUSED, slot, delay);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    mismatch_cnt = 0;
    burst_left   = 0;
    shadow_now   = '0;
    shadow_head  = NSLOT;
    for (int unsigned i = 0; i < NSLOT; i++) begin
      shadow_active[i] = 1'b0;
      shadow_expiry[i] = '0;
      shadow_link[i]   = NSLOT;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_rearm_and_cancel();
    test_unused_code();
    test_fire_cap();
    test_random_traffic(380);

    // drop start, wait for every due result, then let the block settle
    @(negedge clk_i);
    start <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
